// File: design/mpbs_pkg.sv
package mpbs_pkg;

    // input item kinds
    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_OUTCOME = 1'b1;

    // probe outcome codes
    localparam logic [1:0] OUTC_NO_REPLY = 2'd0;
    localparam logic [1:0] OUTC_PASS     = 2'd1;
    localparam logic [1:0] OUTC_DF       = 2'd2;

    // result event codes
    localparam logic [1:0] EV_PROBE   = 2'd0;
    localparam logic [1:0] EV_SUCCESS = 2'd1;
    localparam logic [1:0] EV_FAIL    = 2'd2;

    // configuration register indexes
    localparam logic CFG_MIN_MTU = 1'b0;
    localparam logic CFG_MAX_MTU = 1'b1;

    localparam logic [15:0] MIN_MTU_RST = 16'd576;
    localparam logic [15:0] MAX_MTU_RST = 16'd1500;
    localparam logic [15:0] PING_HDR    = 16'd28;
    localparam logic [15:0] V6_HDR      = 16'd20;
    localparam logic [1:0]  MISS_FAIL   = 2'd3;

    typedef struct packed {
        logic       kind;
        logic [1:0] probe_outcome;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [15:0] probe_mtu;
        logic [15:0] probe_payload;
        logic [15:0] best_mtu;
        logic [15:0] ipv6_mtu;
    } t_out_item;

    typedef struct packed {
        logic [16:0] lower_bound;
        logic [16:0] upper_bound;
        logic [15:0] best_so_far;
        logic [15:0] probe_size;
        logic [1:0]  miss_count;
        logic        last_probe;
        logic        searching;
    } t_search_state;

endpackage

// File: design/mpbs_step.sv
module mpbs_step (
    input  mpbs_pkg::t_search_state i_state,
    input  mpbs_pkg::t_in_item      i_item,
    input  logic [15:0]             i_min_mtu,
    input  logic [15:0]             i_max_mtu,
    output mpbs_pkg::t_search_state o_state,
    output logic                    o_res_vld,
    output mpbs_pkg::t_out_item     o_res
);
    import mpbs_pkg::*;

    t_search_state nx;
    logic          do_head;
    logic          do_best;
    logic          do_fail;
    logic [1:0]    miss_inc;
    logic [16:0]   half;
    logic [16:0]   gap;
    logic [16:0]   probe_sum;

    always_comb begin
        nx        = i_state;
        o_res_vld = 1'b0;
        o_res     = '0;
        do_head   = 1'b0;
        do_best   = 1'b0;
        do_fail   = 1'b0;
        miss_inc  = i_state.miss_count + 2'd1;
        half      = {1'b0, i_state.probe_size} - i_state.lower_bound;
        gap       = '0;
        probe_sum = '0;

        if (i_item.kind == KIND_START) begin
            nx.lower_bound = {1'b0, i_min_mtu};
            nx.upper_bound = {1'b0, i_max_mtu} + 17'd1;
            nx.best_so_far = '0;
            nx.probe_size  = '0;
            nx.miss_count  = '0;
            nx.last_probe  = 1'b0;
            nx.searching   = 1'b1;
            if (i_min_mtu > i_max_mtu) begin
                nx.lower_bound = '0;
                nx.upper_bound = '0;
                do_fail        = 1'b1;
            end else begin
                do_head = 1'b1;
            end
        end else if (i_state.searching) begin
            case (i_item.probe_outcome)
                OUTC_PASS: begin
                    nx.best_so_far = i_state.probe_size;
                    nx.lower_bound = {1'b0, i_state.probe_size};
                end
                OUTC_DF: begin
                    nx.upper_bound = i_state.upper_bound - half;
                end
                default: begin
                    // no reply, or an unused code: count a miss
                    nx.miss_count = miss_inc;
                    if (miss_inc == MISS_FAIL) begin
                        nx.miss_count = '0;
                        do_fail       = 1'b1;
                    end
                end
            endcase
            if (!do_fail) begin
                if (i_state.last_probe) begin
                    do_best = 1'b1;
                end else begin
                    do_head = 1'b1;
                end
            end
        end

        // loop head: close the search or request the midpoint probe
        gap = nx.upper_bound - nx.lower_bound;
        if (do_head) begin
            if (gap <= 17'd1 && nx.lower_bound == {1'b0, nx.best_so_far}) begin
                do_best = 1'b1;
            end else begin
                if (gap <= 17'd1) begin
                    nx.last_probe = 1'b1;
                end
                probe_sum           = nx.lower_bound + (gap >> 1);
                nx.probe_size       = probe_sum[15:0];
                o_res_vld           = 1'b1;
                o_res.event_res     = EV_PROBE;
                o_res.probe_mtu     = probe_sum[15:0];
                o_res.probe_payload = (probe_sum[15:0] > PING_HDR) ?
                                      (probe_sum[15:0] - PING_HDR) : 16'd0;
                o_res.best_mtu      = nx.best_so_far;
            end
        end

        if (do_best) begin
            if (nx.best_so_far == 16'd0) begin
                do_fail = 1'b1;
            end else begin
                nx.searching    = 1'b0;
                nx.last_probe   = 1'b0;
                o_res_vld       = 1'b1;
                o_res.event_res = EV_SUCCESS;
                o_res.best_mtu  = nx.best_so_far;
                o_res.ipv6_mtu  = (nx.best_so_far > V6_HDR) ?
                                  (nx.best_so_far - V6_HDR) : 16'd0;
            end
        end

        if (do_fail) begin
            nx.searching = 1'b0;
            nx.last_probe = 1'b0;
            o_res_vld    = 1'b1;
            o_res        = '0;
            o_res.event_res = EV_FAIL;
        end

        o_state = nx;
    end

endmodule

// File: design/mtu_probe_binary_search_unit.sv
// Path-MTU binary search controller.
// Input channel (i_in_valid / o_in_stall / i_in_data): a start item opens a
// search over [min_mtu, max_mtu]; an outcome item reports the result of the
// outstanding probe (no reply, passed, or DF refused).
// Output channel (o_out_valid / i_out_stall / o_out_data): one result per
// item at most: a probe request, a success with the final MTU, or a failure.
// Outcome items that arrive while no search runs give no result.
// Configuration: i_cfg_we writes min_mtu (index 0) or max_mtu (index 1);
// write only while the block is idle. A new value applies at the next start.
// Path: an accepted item is held in the input register until the search step
// processes it, and its result is then written to the result register.
// Throughput: one item per cycle unless the output stalls; the whole step is
// a single pass of subtract, halve, add and compare between the two registers.
// Reset (synchronous, active low) empties both registers, clears the search
// state and loads min_mtu = 576 and max_mtu = 1500.
// A stall on the output holds the result register; the held input item then
// raises o_in_stall in the same cycle, so no item is lost or reordered.
module mtu_probe_binary_search_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mpbs_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mpbs_pkg::t_out_item o_out_data,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import mpbs_pkg::*;

    logic          r_in_vld;
    t_in_item      r_in_item;
    logic          r_out_vld;
    t_out_item     r_out_item;
    t_search_state r_state;
    logic [15:0]   r_min_mtu;
    logic [15:0]   r_max_mtu;

    t_search_state n_state;
    t_out_item     n_res;
    logic          n_res_vld;
    logic          out_free;
    logic          proc;
    logic          in_xfer;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign proc       = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    mpbs_step u_step (
        .i_state   (r_state),
        .i_item    (r_in_item),
        .i_min_mtu (r_min_mtu),
        .i_max_mtu (r_max_mtu),
        .o_state   (n_state),
        .o_res_vld (n_res_vld),
        .o_res     (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '0;
            r_min_mtu <= MIN_MTU_RST;
            r_max_mtu <= MAX_MTU_RST;
        end else begin
            if (in_xfer) begin
                r_in_vld <= 1'b1;
            end else if (proc) begin
                r_in_vld <= 1'b0;
            end
            if (proc) begin
                r_state   <= n_state;
                r_out_vld <= n_res_vld;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MIN_MTU: r_min_mtu <= i_cfg_data;
                    CFG_MAX_MTU: r_max_mtu <= i_cfg_data;
                    default:     r_min_mtu <= r_min_mtu;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_item <= i_in_data;
        end
        if (proc && n_res_vld) begin
            r_out_item <= n_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_item;

`ifndef NO_ASSERTIONS
    a_end_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && n_res_vld && n_res.event_res != EV_PROBE) |=> !r_state.searching)
        else $error("search still running after a final result");

    a_probe_keeps_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && n_res_vld && n_res.event_res == EV_PROBE) |=> r_state.searching)
        else $error("probe requested but search not running");

    a_miss_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.miss_count != MISS_FAIL)
        else $error("miss counter passed the failure limit");

    a_success_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.event_res == EV_SUCCESS) |-> o_out_data.best_mtu != 16'd0)
        else $error("success reported with zero best size");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_vld && r_out_vld))
        else $error("input stalled with room to advance");
`endif

endmodule
